// ===== rtl/agmp_pkg.sv =====
// ----------------------------------------------------------------------------
// agmp_pkg
// Shared types and constants for the autoincrement graphics memory port.
// ----------------------------------------------------------------------------
package agmp_pkg;

	localparam int DEF_COLUMNS = 128;
	localparam int DEF_ROWS    = 256;

	localparam int ACTION_W = 3;
	localparam int BYTE_W   = 8;
	localparam int DCOL_W   = 7;
	localparam int CFG_IDX_W = 1;

	// Bus actions.
	localparam logic [ACTION_W-1:0] ACT_SET_X   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SET_Y   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WR_DATA = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RD_DATA = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_WR_MODE = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SCROLL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCROLL    = 1'd1;

	// Mode byte bit positions.
	localparam int MODE_ENABLE  = 0;
	localparam int MODE_XDEC    = 2;
	localparam int MODE_YDEC    = 3;
	localparam int MODE_XHOLD_RD = 4;
	localparam int MODE_YHOLD_RD = 5;
	localparam int MODE_XHOLD_WR = 6;
	localparam int MODE_YHOLD_WR = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic set_x;
		logic set_y;
		logic wr_data;
		logic rd_data;
		logic wr_mode;
	} agmp_cmd_t;

endpackage

// ===== rtl/agmp_if.sv =====
// ----------------------------------------------------------------------------
// agmp_if
// Valid/ready channels for bus access items and their result items.
// ----------------------------------------------------------------------------
interface agmp_in_if;
	logic                          valid;
	logic                          ready;
	logic [agmp_pkg::ACTION_W-1:0] action;
	logic [agmp_pkg::BYTE_W-1:0]   data_in;

	modport source(output valid, output action, output data_in, input ready);
	modport sink(input valid, input action, input data_in, output ready);
endinterface

interface agmp_out_if;
	logic                        valid;
	logic                        ready;
	logic [agmp_pkg::BYTE_W-1:0] read_value;
	logic                        draw_valid;
	logic [agmp_pkg::DCOL_W-1:0] draw_column;
	logic [agmp_pkg::BYTE_W-1:0] draw_row;
	logic [agmp_pkg::BYTE_W-1:0] draw_byte;
	logic                        graphics_enabled;
	logic                        enable_changed;

	modport source(output valid, output read_value, output draw_valid, output draw_column,
		output draw_row, output draw_byte, output graphics_enabled, output enable_changed,
		input ready);
	modport sink(input valid, input read_value, input draw_valid, input draw_column,
		input draw_row, input draw_byte, input graphics_enabled, input enable_changed,
		output ready);
endinterface

// ===== rtl/agmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// agmp_ctrl
// Handshake controller: tracks the output register and decodes each item.
// ----------------------------------------------------------------------------
module agmp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [agmp_pkg::ACTION_W-1:0] in_action,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output agmp_pkg::agmp_cmd_t           cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// A new item may enter while the held result is being taken.
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (accept) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (accept) state_d = ST_FULL;
				else if (out_ready) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_EMPTY;
		else state_q <= state_d;
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		unique case (in_action)
			agmp_pkg::ACT_SET_X:   cmd.set_x   = accept;
			agmp_pkg::ACT_SET_Y:   cmd.set_y   = accept;
			agmp_pkg::ACT_WR_DATA: cmd.wr_data = accept;
			agmp_pkg::ACT_RD_DATA: cmd.rd_data = accept;
			agmp_pkg::ACT_WR_MODE: cmd.wr_mode = accept;
			default: ;
		endcase
	end

endmodule

// ===== rtl/agmp_dp.sv =====
// ----------------------------------------------------------------------------
// agmp_dp
// Datapath: address and mode registers, scroll registers, pixel memory and
// the result register.
// ----------------------------------------------------------------------------
module agmp_dp #(
	parameter int COLUMNS = agmp_pkg::DEF_COLUMNS,
	parameter int ROWS    = agmp_pkg::DEF_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  agmp_pkg::agmp_cmd_t            cmd,
	input  logic [agmp_pkg::BYTE_W-1:0]    data_in,
	input  logic                           cfg_we,
	input  logic [agmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [agmp_pkg::BYTE_W-1:0]    cfg_data,
	output logic [agmp_pkg::BYTE_W-1:0]    read_value,
	output logic                           draw_valid,
	output logic [agmp_pkg::DCOL_W-1:0]    draw_column,
	output logic [agmp_pkg::BYTE_W-1:0]    draw_row,
	output logic [agmp_pkg::BYTE_W-1:0]    draw_byte,
	output logic                           graphics_enabled,
	output logic                           enable_changed
);

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int DEPTH  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LUT_N  = 1 << agmp_pkg::BYTE_W;

	logic [agmp_pkg::BYTE_W-1:0] x_q, y_q, mode_q, row_scroll_q;
	logic [agmp_pkg::DCOL_W-1:0] column_scroll_q;

	// Constant tables for a byte taken modulo the column and row counts.
	logic [COL_W-1:0] col_lut [LUT_N];
	logic [ROW_W-1:0] row_lut [LUT_N];

	for (genvar i = 0; i < LUT_N; i++) begin : g_lut
		assign col_lut[i] = COL_W'(i % COLUMNS);
		assign row_lut[i] = ROW_W'(i % ROWS);
	end

	logic [COL_W-1:0]  col, cs;
	logic [ROW_W-1:0]  row, rs;
	logic [COL_W:0]    dc_sum, dc;
	logic [ROW_W:0]    dr_sum, dr;
	logic [ADDR_W-1:0] addr;

	assign col = col_lut[x_q];
	assign row = row_lut[y_q];
	assign cs  = col_lut[{1'b0, column_scroll_q}];
	assign rs  = row_lut[row_scroll_q];

	// Both terms are below the modulus, so one conditional subtract wraps.
	assign dc_sum = {1'b0, col} + (COL_W+1)'(COLUMNS) - {1'b0, cs};
	assign dc     = (dc_sum >= (COL_W+1)'(COLUMNS)) ? dc_sum - (COL_W+1)'(COLUMNS) : dc_sum;
	assign dr_sum = {1'b0, row} + (ROW_W+1)'(ROWS) - {1'b0, rs};
	assign dr     = (dr_sum >= (ROW_W+1)'(ROWS)) ? dr_sum - (ROW_W+1)'(ROWS) : dr_sum;

	assign addr = ADDR_W'(row * COLUMNS) + ADDR_W'(col);

	logic x_hold, y_hold, step;

	always_comb begin
		step   = cmd.wr_data || cmd.rd_data;
		x_hold = cmd.wr_data ? mode_q[agmp_pkg::MODE_XHOLD_WR] : mode_q[agmp_pkg::MODE_XHOLD_RD];
		y_hold = cmd.wr_data ? mode_q[agmp_pkg::MODE_YHOLD_WR] : mode_q[agmp_pkg::MODE_YHOLD_RD];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			mode_q <= '0;
		end else begin
			if (cmd.set_x) x_q <= data_in;
			else if (step && !x_hold) begin
				x_q <= mode_q[agmp_pkg::MODE_XDEC] ? x_q - 8'd1 : x_q + 8'd1;
			end
			if (cmd.set_y) y_q <= data_in;
			else if (step && !y_hold) begin
				y_q <= mode_q[agmp_pkg::MODE_YDEC] ? y_q - 8'd1 : y_q + 8'd1;
			end
			if (cmd.wr_mode) mode_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_scroll_q <= '0;
			row_scroll_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				agmp_pkg::CFG_COLUMN_SCROLL: column_scroll_q <= cfg_data[agmp_pkg::DCOL_W-1:0];
				agmp_pkg::CFG_ROW_SCROLL:    row_scroll_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [agmp_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [agmp_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_data) mem[addr] <= data_in;
		if (cmd.rd_data) rdata_q <= mem[addr];
	end

	logic                        rd_sel_q;
	logic                        draw_valid_q;
	logic [agmp_pkg::DCOL_W-1:0] draw_column_q;
	logic [agmp_pkg::BYTE_W-1:0] draw_row_q, draw_byte_q;
	logic                        enable_changed_q;
	logic                        draw_now;

	assign draw_now = cmd.wr_data && mode_q[agmp_pkg::MODE_ENABLE];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_sel_q         <= cmd.rd_data;
			draw_valid_q     <= draw_now;
			draw_column_q    <= draw_now ? agmp_pkg::DCOL_W'(dc) : '0;
			draw_row_q       <= draw_now ? agmp_pkg::BYTE_W'(dr) : '0;
			draw_byte_q      <= draw_now ? data_in : '0;
			enable_changed_q <= cmd.wr_mode &&
				(data_in[agmp_pkg::MODE_ENABLE] != mode_q[agmp_pkg::MODE_ENABLE]);
		end
	end

	assign read_value       = rd_sel_q ? rdata_q : '0;
	assign draw_valid       = draw_valid_q;
	assign draw_column      = draw_column_q;
	assign draw_row         = draw_row_q;
	assign draw_byte        = draw_byte_q;
	assign graphics_enabled = mode_q[agmp_pkg::MODE_ENABLE];
	assign enable_changed   = enable_changed_q;

endmodule

// ===== rtl/autoincrement_graphics_memory_port_unit.sv =====
// ----------------------------------------------------------------------------
// autoincrement_graphics_memory_port_unit
// Register-mapped graphics memory with auto-stepping X and Y addresses.
// ----------------------------------------------------------------------------
// Each bus access enters as one item on in_ch (action, data_in) and yields
// exactly one result item on out_ch. Actions set X, set Y, write a data byte,
// read a data byte or write the mode byte; data accesses step X and Y as the
// mode byte directs, and a data write while enabled also reports a draw at
// the scrolled screen position. Scroll offsets come in on the write port
// (cfg_we, cfg_index, cfg_data); the user writes them only while the block
// is idle, which the block itself does not enforce. Results are registered
// and show in the cycle after acceptance; the pixel memory is read through
// its registered port at the accepting edge. Throughput is one item per cycle
// while out_ch is not stalled, set by the single memory port used once per
// item. A result waits in the output register while out_ch is stalled; a new
// item is taken in the same cycle the waiting result is taken, never earlier.
// Reset clears X, Y, the mode byte, the scroll registers and out_valid, not
// the output data or the pixel memory: a cell reads back only after a write.
// ----------------------------------------------------------------------------
module autoincrement_graphics_memory_port_unit #(
	parameter int COLUMNS = agmp_pkg::DEF_COLUMNS,
	parameter int ROWS    = agmp_pkg::DEF_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	agmp_in_if.sink                        in_ch,
	agmp_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [agmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [agmp_pkg::BYTE_W-1:0]    cfg_data
);

	agmp_pkg::agmp_cmd_t cmd;

	agmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	agmp_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.data_in          (in_ch.data_in),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.read_value       (out_ch.read_value),
		.draw_valid       (out_ch.draw_valid),
		.draw_column      (out_ch.draw_column),
		.draw_row         (out_ch.draw_row),
		.draw_byte        (out_ch.draw_byte),
		.graphics_enabled (out_ch.graphics_enabled),
		.enable_changed   (out_ch.enable_changed)
	);

	// A draw is only reported while graphics is enabled.
	a_draw_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.draw_valid) |-> out_ch.graphics_enabled)
		else $error("draw reported while graphics disabled");

	// A nonzero read byte comes only from a read, which neither draws nor changes mode.
	a_read_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.read_value != '0) |-> (!out_ch.draw_valid && !out_ch.enable_changed))
		else $error("read result carries draw or enable change");

	// Every accepted item shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> out_ch.valid)
		else $error("accepted item produced no result");

	// A mode write that flips the enable bit is flagged.
	a_enable_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.action == agmp_pkg::ACT_WR_MODE &&
		 in_ch.data_in[agmp_pkg::MODE_ENABLE] != out_ch.graphics_enabled)
		|=> (out_ch.valid && out_ch.enable_changed))
		else $error("enable toggle not flagged");

endmodule
